>>> rtl/iee_pkg.sv
`timescale 1ns / 1ps

package iee_pkg;

	// character codes
	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_SPACE   = 8'd32;
	localparam logic [7:0] CH_ZERO    = 8'd48;
	localparam logic [7:0] CH_NINE    = 8'd57;
	localparam logic [7:0] CH_STAR    = 8'd42;
	localparam logic [7:0] CH_SLASH   = 8'd47;
	localparam logic [7:0] CH_PERCENT = 8'd37;
	localparam logic [7:0] CH_PLUS    = 8'd43;
	localparam logic [7:0] CH_MINUS   = 8'd45;

	// error codes on the result
	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_DIVZERO = 2'd1;
	localparam logic [1:0] ERR_UNKNOWN = 2'd2;

	// pending multiplicative operator of the running term
	typedef enum logic [1:0] {
		OP_NONE,
		OP_MUL,
		OP_DIV,
		OP_MOD
	} op_t;

	// what to do once the running term has been folded
	typedef enum logic [2:0] {
		POST_MUL,
		POST_DIV,
		POST_MOD,
		POST_ADD,
		POST_SUB,
		POST_ADD_ERR,
		POST_EMIT
	} post_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ITER,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic digit;
		logic commit_acc;
		logic start;
		logic commit_unit;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic is_space;
		logic is_digit;
		logic is_newline;
		logic have_number;
		logic op_pending;
		logic unit_busy;
		logic post_emit;
		logic out_free;
	} sts_t;

	function automatic post_t post_of(input logic [7:0] c);
		post_t p;
		case (c)
			CH_STAR:    p = POST_MUL;
			CH_SLASH:   p = POST_DIV;
			CH_PERCENT: p = POST_MOD;
			CH_PLUS:    p = POST_ADD;
			CH_MINUS:   p = POST_SUB;
			CH_NEWLINE: p = POST_EMIT;
			default:    p = POST_ADD_ERR;
		endcase
		return p;
	endfunction

endpackage

>>> rtl/iee_ctrl.sv
`timescale 1ns / 1ps

module iee_ctrl import iee_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (sts.is_digit) begin
						cmd.digit = 1'b1;
					end else if (sts.is_newline) begin
						if (sts.op_pending) begin
							cmd.start = 1'b1;
							state_d   = S_ITER;
						end else begin
							cmd.commit_acc = 1'b1;
							state_d        = S_EMIT;
						end
					end else if (!sts.is_space && sts.have_number) begin
						if (sts.op_pending) begin
							cmd.start = 1'b1;
							state_d   = S_ITER;
						end else begin
							cmd.commit_acc = 1'b1;
						end
					end
				end
			end
			S_ITER: begin
				// wait out the shared multiply/divide unit, then fold its result
				if (!sts.unit_busy) begin
					cmd.commit_unit = 1'b1;
					state_d         = sts.post_emit ? S_EMIT : S_IDLE;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/iee_dp.sv
`timescale 1ns / 1ps

module iee_dp import iee_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  char_code,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic        out_stall,
	output logic        out_valid,
	output logic [31:0] value,
	output logic [1:0]  error_code
);

	localparam int VB = VALUE_BITS;
	localparam int CW = $clog2(VB + 1);

	logic [VB-1:0] acc_q, term_q, sum_q;
	logic          have_q, sneg_q;
	op_t           op_q;
	post_t         post_q;
	logic [1:0]    err_q;

	logic [VB-1:0] r_q, x_q, y_q;
	logic          na_q, nb_q, busy_q;
	logic [CW-1:0] cnt_q;

	logic          out_valid_q;
	logic [31:0]   value_q;
	logic [1:0]    errc_q;

	logic          is_digit;
	logic [3:0]    digit;
	logic [VB-1:0] acc_next;
	post_t         post_in, post_sel;
	logic [VB-1:0] term_new, add_opnd, sum_fold;
	logic          a_neg, b_neg, div_zero;
	logic [VB-1:0] a_mag, b_mag, mul_sum, quo_fix, rem_fix, fix_val;
	logic [VB:0]   shifted, diff;

	assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign digit    = 4'(char_code - CH_ZERO);
	assign acc_next = (acc_q << 3) + (acc_q << 1) + VB'(digit);
	assign post_in  = post_of(char_code);

	// shared unit: the term is the dividend / multiplicand, the number the other operand
	assign a_neg   = term_q[VB-1];
	assign b_neg   = acc_q[VB-1];
	assign a_mag   = a_neg ? (~term_q + 1'b1) : term_q;
	assign b_mag   = b_neg ? (~acc_q + 1'b1) : acc_q;
	assign mul_sum = r_q + (x_q[0] ? y_q : '0);
	assign shifted = {r_q, x_q[VB-1]};
	assign diff    = shifted - {1'b0, y_q};
	assign quo_fix = (na_q ^ nb_q) ? (~x_q + 1'b1) : x_q;
	assign rem_fix = na_q ? (~r_q + 1'b1) : r_q;

	always_comb begin
		case (op_q)
			OP_MUL:  fix_val = r_q;
			OP_DIV:  fix_val = (y_q == '0) ? '0 : quo_fix;
			OP_MOD:  fix_val = (y_q == '0) ? '0 : rem_fix;
			default: fix_val = r_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(VB);
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			na_q <= a_neg;
			nb_q <= b_neg;
			r_q  <= '0;
			if (op_q == OP_MUL) begin
				x_q <= acc_q;
				y_q <= term_q;
			end else begin
				x_q <= a_mag;
				y_q <= b_mag;
			end
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				if (op_q == OP_MUL) begin
					r_q <= mul_sum;
					x_q <= x_q >> 1;
					y_q <= y_q << 1;
				end else if (!diff[VB]) begin
					r_q <= diff[VB-1:0];
					x_q <= {x_q[VB-2:0], 1'b1};
				end else begin
					r_q <= shifted[VB-1:0];
					x_q <= {x_q[VB-2:0], 1'b0};
				end
			end else begin
				r_q <= fix_val;
			end
		end
	end

	// fold of the running term into the sum; emit reuses the same adder on the stored term
	assign term_new = cmd.commit_unit ? r_q : acc_q;
	assign post_sel = cmd.commit_unit ? post_q : post_in;
	assign add_opnd = cmd.emit ? term_q : term_new;
	assign sum_fold = sneg_q ? (sum_q - add_opnd) : (sum_q + add_opnd);
	assign div_zero = cmd.commit_unit && (op_q != OP_MUL) && (acc_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			have_q <= 1'b0;
			term_q <= '0;
			op_q   <= OP_NONE;
			sum_q  <= '0;
			sneg_q <= 1'b0;
			err_q  <= ERR_NONE;
			post_q <= POST_ADD;
		end else begin
			if (cmd.start) begin
				post_q <= post_in;
			end
			if (cmd.emit) begin
				acc_q  <= '0;
				have_q <= 1'b0;
				term_q <= '0;
				op_q   <= OP_NONE;
				sum_q  <= '0;
				sneg_q <= 1'b0;
				err_q  <= ERR_NONE;
			end else if (cmd.commit_acc || cmd.commit_unit) begin
				acc_q  <= '0;
				have_q <= 1'b0;
				term_q <= term_new;
				if (err_q == ERR_NONE) begin
					if (div_zero) begin
						err_q <= ERR_DIVZERO;
					end else if (post_sel == POST_ADD_ERR) begin
						err_q <= ERR_UNKNOWN;
					end
				end
				case (post_sel)
					POST_MUL: op_q <= OP_MUL;
					POST_DIV: op_q <= OP_DIV;
					POST_MOD: op_q <= OP_MOD;
					POST_ADD, POST_SUB, POST_ADD_ERR: begin
						sum_q  <= sum_fold;
						term_q <= '0;
						op_q   <= OP_NONE;
						sneg_q <= (post_sel == POST_SUB);
					end
					default: begin
						// newline: hold the term for the emit step
					end
				endcase
			end else if (cmd.digit) begin
				acc_q  <= acc_next;
				have_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			value_q <= (err_q != ERR_NONE) ? '0 : 32'($signed(sum_fold));
			errc_q  <= err_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign value      = value_q;
	assign error_code = errc_q;

	assign sts.is_space    = (char_code == CH_SPACE);
	assign sts.is_digit    = is_digit;
	assign sts.is_newline  = (char_code == CH_NEWLINE);
	assign sts.have_number = have_q;
	assign sts.op_pending  = (op_q != OP_NONE);
	assign sts.unit_busy   = busy_q;
	assign sts.post_emit   = (post_q == POST_EMIT);
	assign sts.out_free    = !out_valid_q || !out_stall;

endmodule

>>> rtl/infix_expression_evaluator_unit.sv
`timescale 1ns / 1ps
// Infix expression evaluator: takes one ASCII character per request on the input
// channel (in_valid / in_stall / char_code) and evaluates + - * / % expressions
// with the usual precedence, left to right, wrapping at VALUE_BITS bits.
// A newline ends the expression; one result request (value, error_code) then
// leaves on the output channel (out_valid / out_stall) and all state clears.
// Stalls: spaces, digits and an operator that follows no pending * / % go
// through without a stall. An operator or newline that closes a pending * / %
// runs the shared shift-add multiplier / restoring divider: VALUE_BITS steps
// plus a sign-fix step and a fold step, with the input stalled throughout.
// A newline also passes through an emit step that loads the output register.
// The result sits in an output register, so characters keep flowing while it
// waits; only the next newline holds in its emit step while out_stall is high.
// Reset (arst_n low) clears the running number, term, sum, error and the
// output valid; in_stall is low right after reset.

module infix_expression_evaluator_unit import iee_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] value,
	output logic [1:0]  error_code
);

	cmd_t cmd;
	sts_t sts;

	// sequencing: idle/accept, iterate the arithmetic unit, emit the result
	iee_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// number, term and sum registers, the iterative unit and the output register
	iee_dp #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_code  (char_code),
		.cmd        (cmd),
		.sts        (sts),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.value      (value),
		.error_code (error_code)
	);

	// a newline always leaves the accept state for a fold or the emit step
	a_newline_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && char_code == CH_NEWLINE) |=> in_stall)
		else $error("newline accepted without leaving idle");

	// a space never starts any work
	a_space_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && char_code == CH_SPACE) |=> !in_stall)
		else $error("space caused the block to stall");

	// an errored result carries a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error_code != ERR_NONE) |-> (value == 32'd0))
		else $error("nonzero value with error");

	// error codes stay within the defined set
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (error_code == ERR_NONE || error_code == ERR_DIVZERO ||
			error_code == ERR_UNKNOWN))
		else $error("undefined error code");

endmodule
